### sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Widths, operation codes and the handshake type between the sequencer and
// the reduction unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int NUM_W         = 2 * OPERAND_WIDTH + 1;
  localparam int DEN_W         = 2 * OPERAND_WIDTH;
  localparam int MAG_W         = NUM_W;
  localparam int CNT_W         = $clog2(MAG_W);
  localparam int S_TDATA_W     = ((4 * OPERAND_WIDTH + 2 + 7) / 8) * 8;
  localparam int M_TDATA_W     = ((NUM_W + DEN_W + 1 + 7) / 8) * 8;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef struct packed {
    logic done;
    logic err;
  } rau_rsp_t;

endpackage

### sv/rau_reduce.sv
// ----------------------------------------------------------------------------
// rau_reduce: fraction reduction by gcd
// Binary gcd of the two magnitudes, then two restoring divisions, all on one
// shared subtractor.
// ----------------------------------------------------------------------------
module rau_reduce import rau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] n_in,
  input  logic signed [NUM_W-1:0] d_in,
  output logic signed [NUM_W-1:0] n_out,
  output logic signed [NUM_W-1:0] d_out,
  output rau_rsp_t                rsp
);

  typedef enum logic [5:0] {
    R_IDLE = 6'b000001,
    R_EVEN = 6'b000010,
    R_ODD  = 6'b000100,
    R_DIVN = 6'b001000,
    R_DIVD = 6'b010000,
    R_DONE = 6'b100000
  } red_state_t;

  red_state_t       state;
  logic [MAG_W-1:0] x;
  logic [MAG_W-1:0] y;
  logic [MAG_W-1:0] q;
  logic [MAG_W-1:0] r;
  logic [MAG_W-1:0] dsrc;
  logic [MAG_W-1:0] nquo;
  logic [CNT_W-1:0] cnt;
  logic             n_neg;
  logic             d_neg;
  logic             err;

  logic [MAG_W-1:0] n_mag;
  logic [MAG_W-1:0] d_mag;
  logic [MAG_W:0]   sub_a;
  logic [MAG_W:0]   sub_b;
  logic [MAG_W+1:0] diff;
  logic             neg;
  logic [MAG_W-1:0] q_shift;
  logic [MAG_W-1:0] r_next;
  logic             cnt_last;

  assign n_mag = n_in[NUM_W-1] ? MAG_W'(-n_in) : MAG_W'(n_in);
  assign d_mag = d_in[NUM_W-1] ? MAG_W'(-d_in) : MAG_W'(d_in);

  // The one subtractor compares during gcd and trial-subtracts during division.
  always_comb begin
    if (state == R_ODD) begin
      sub_a = {1'b0, x};
      sub_b = {1'b0, y};
    end else begin
      sub_a = {r, q[MAG_W-1]};
      sub_b = {1'b0, x};
    end
  end

  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign neg      = diff[MAG_W+1];
  assign q_shift  = {q[MAG_W-2:0], ~neg};
  assign r_next   = neg ? sub_a[MAG_W-1:0] : diff[MAG_W-1:0];
  assign cnt_last = (cnt == CNT_W'(MAG_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      case (state)
        R_IDLE: begin
          if (start) begin
            n_neg <= n_in[NUM_W-1];
            d_neg <= d_in[NUM_W-1];
            x     <= n_mag;
            y     <= d_mag;
            if (d_in == '0) begin
              err   <= 1'b1;
              n_out <= '0;
              d_out <= '0;
              state <= R_DONE;
            end else if (n_in == '0) begin
              err   <= 1'b0;
              n_out <= n_in;
              d_out <= d_in;
              state <= R_DONE;
            end else begin
              err   <= 1'b0;
              state <= R_EVEN;
            end
          end
        end
        R_EVEN: begin
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
          end else begin
            q     <= x;
            dsrc  <= y;
            state <= R_ODD;
          end
        end
        R_ODD: begin
          if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (diff == '0) begin
            r     <= '0;
            cnt   <= '0;
            state <= R_DIVN;
          end else if (neg) begin
            x <= y;
            y <= x;
          end else begin
            x <= diff[MAG_W:1];
          end
        end
        R_DIVN: begin
          q   <= q_shift;
          r   <= r_next;
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            nquo  <= q_shift;
            q     <= dsrc;
            r     <= '0;
            cnt   <= '0;
            state <= R_DIVD;
          end
        end
        R_DIVD: begin
          q   <= q_shift;
          r   <= r_next;
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            n_out <= n_neg ? $signed(-nquo) : $signed(nquo);
            d_out <= d_neg ? $signed(-q_shift) : $signed(q_shift);
            state <= R_DONE;
          end
        end
        R_DONE: begin
          state <= R_IDLE;
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = (state == R_DONE);
  assign rsp.err  = err;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == R_IDLE)
    else $error("reduction started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("reduction done held longer than one cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.done && rsp.err |-> n_out == '0 && d_out == '0)
    else $error("error result not cleared");

endmodule

### sv/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit: rational add, subtract, multiply and divide
// Sequencer with one shared multiplier around the gcd reduction unit.
//
//   Channel  Dir  Word contents
//   s_*      in   func, a_num, a_den, b_num, b_den
//   m_*      out  res_num, res_den, err_code
//
// An item ends soonest when the first reduction sees a zero denominator, and
// early when a reduction sees a zero numerator. Subtract and divide take
// longer than add and multiply, since they reduce twice. Each reduction in
// rau_reduce runs the binary gcd loop and then two restoring divisions on the
// shared subtractor. It runs once on the final fraction, and first on the
// second operand for subtract and divide.
// Reset is synchronous and clears only control state.
// A new word is accepted only after the previous result has been taken.
// ----------------------------------------------------------------------------
module rational_arith_unit import rau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // func[1:0], a_num[17:2], a_den[33:18], b_num[49:34], b_den[65:50], zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // res_num[32:0], res_den[64:33], err_code[65], zero pad
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [8:0] {
    T_IDLE  = 9'b000000001,
    T_PRE   = 9'b000000010,
    T_PWAIT = 9'b000000100,
    T_M1    = 9'b000001000,
    T_M2    = 9'b000010000,
    T_M3    = 9'b000100000,
    T_M4    = 9'b001000000,
    T_RWAIT = 9'b010000000,
    T_OUT   = 9'b100000000
  } top_state_t;

  top_state_t               state;
  func_t                    func;
  logic signed [W:0]        an;
  logic signed [W:0]        ad;
  logic signed [W:0]        bn;
  logic signed [W:0]        bd;
  logic signed [2*W+1:0]    prod;
  logic signed [NUM_W-1:0]  rn;
  logic signed [NUM_W-1:0]  res_num;
  logic signed [DEN_W-1:0]  res_den;
  logic                     res_err;

  logic                     addsub;
  logic signed [W:0]        mul_a;
  logic signed [W:0]        mul_b;
  logic                     red_start;
  logic signed [NUM_W-1:0]  red_n;
  logic signed [NUM_W-1:0]  red_d;
  logic signed [NUM_W-1:0]  red_n_out;
  logic signed [NUM_W-1:0]  red_d_out;
  rau_rsp_t                 red_rsp;

  assign addsub = (func == FUNC_ADD) || (func == FUNC_SUB);

  always_comb begin
    case (state)
      T_M1: begin
        mul_a = an;
        mul_b = addsub ? bd : bn;
      end
      T_M2: begin
        mul_a = bn;
        mul_b = ad;
      end
      default: begin
        mul_a = ad;
        mul_b = bd;
      end
    endcase
  end

  always_comb begin
    red_start = 1'b0;
    red_n     = rn;
    red_d     = prod[NUM_W-1:0];
    if (state == T_PRE) begin
      red_start = (func == FUNC_SUB) || (func == FUNC_DIV);
      if (func == FUNC_SUB) begin
        red_n = NUM_W'(-bn);
        red_d = NUM_W'(bd);
      end else begin
        red_n = NUM_W'(bd);
        red_d = NUM_W'(bn);
      end
    end else if (state == T_M4) begin
      red_start = 1'b1;
    end
  end

  rau_reduce u_reduce (
    .clk   (clk),
    .rst   (rst),
    .start (red_start),
    .n_in  (red_n),
    .d_in  (red_d),
    .n_out (red_n_out),
    .d_out (red_d_out),
    .rsp   (red_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      case (state)
        T_IDLE: begin
          if (s_tvalid) begin
            func  <= func_t'(s_tdata[1:0]);
            an    <= (W+1)'($signed(s_tdata[W+1:2]));
            ad    <= (W+1)'($signed(s_tdata[2*W+1:W+2]));
            bn    <= (W+1)'($signed(s_tdata[3*W+1:2*W+2]));
            bd    <= (W+1)'($signed(s_tdata[4*W+1:3*W+2]));
            state <= T_PRE;
          end
        end
        T_PRE: begin
          state <= red_start ? T_PWAIT : T_M1;
        end
        T_PWAIT: begin
          if (red_rsp.done) begin
            if (red_rsp.err) begin
              res_num <= '0;
              res_den <= '0;
              res_err <= 1'b1;
              state   <= T_OUT;
            end else begin
              bn    <= red_n_out[W:0];
              bd    <= red_d_out[W:0];
              state <= T_M1;
            end
          end
        end
        T_M1: begin
          prod  <= mul_a * mul_b;
          state <= T_M2;
        end
        T_M2: begin
          rn    <= prod[NUM_W-1:0];
          prod  <= mul_a * mul_b;
          state <= T_M3;
        end
        T_M3: begin
          if (addsub) begin
            rn <= rn + prod[NUM_W-1:0];
          end
          prod  <= mul_a * mul_b;
          state <= T_M4;
        end
        T_M4: begin
          state <= T_RWAIT;
        end
        T_RWAIT: begin
          if (red_rsp.done) begin
            res_num <= red_n_out;
            res_den <= red_d_out[DEN_W-1:0];
            res_err <= red_rsp.err;
            state   <= T_OUT;
          end
        end
        T_OUT: begin
          if (m_tready) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == T_IDLE);
  assign m_tvalid = (state == T_OUT);
  assign m_tdata  = M_TDATA_W'({res_err, res_den, res_num});

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output active together");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_err |-> res_num == '0 && res_den == '0)
    else $error("error result carries nonzero fields");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    red_rsp.done |-> state == T_PWAIT || state == T_RWAIT)
    else $error("reduction finished while not awaited");

endmodule
